// ----- src/hmap_pkg.sv -----
package hmap_pkg;

  // Fixed widths of the request and result fields, the table size and the remainder digit.
  localparam int DATA_W   = 32;
  localparam int TS_W     = 11;
  localparam int FUNC_W   = 2;
  localparam int DIGIT_W  = 4;

  // Defaults for the top level parameters.
  localparam int DEPTH_DEF     = 1024;
  localparam int KEY_WIDTH_DEF = 32;

  // Register reset values.
  localparam logic [TS_W-1:0]   TABLE_SIZE_RST = TS_W'(1024);
  localparam logic [DATA_W-1:0] KEY_LOW_RST    = '0;

  // Register indexes on the configuration port.
  localparam logic REG_TABLE_SIZE = 1'b0;
  localparam logic REG_KEY_LOW    = 1'b1;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET   = 2'd0,
    FUNC_GET   = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_LOOKUP,
    ST_PROBE,
    ST_CLEAR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              found;
    logic              full_res;
  } rsp_t;

  typedef struct packed {
    logic [TS_W-1:0]   table_size;
    logic [DATA_W-1:0] key_low;
  } cfg_t;

  typedef struct packed {
    logic key_we;
    logic val_we;
  } mem_ctl_t;

endpackage

// ----- src/hmap_cfg.sv -----
module hmap_cfg import hmap_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [TS_W-1:0]   table_size_q;
  logic [DATA_W-1:0] key_low_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes; the word index is taken from the upper address bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TABLE_SIZE_RST;
      key_low_q    <= KEY_LOW_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TABLE_SIZE: table_size_q <= pwdata[TS_W-1:0];
        REG_KEY_LOW:    key_low_q    <= pwdata;
        default:        ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (paddr[2])
      REG_TABLE_SIZE: prdata = DATA_W'(table_size_q);
      REG_KEY_LOW:    prdata = key_low_q;
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.table_size = table_size_q;
  assign cfg_o.key_low    = key_low_q;

endmodule

// ----- src/hmap_mod.sv -----
module hmap_mod import hmap_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [KEY_WIDTH-1:0] dividend_i,
  input  logic [TS_W-1:0]      divisor_i,
  output logic                 done_o,
  output logic [TS_W-1:0]      rem_o
);

  localparam int Digits = (KEY_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int PadW   = Digits * DIGIT_W;
  localparam int CntW   = $clog2(Digits + 1);
  localparam int AccW   = TS_W + DIGIT_W;

  logic [PadW-1:0] sh_q;
  logic [TS_W-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic [TS_W-1:0] rem_next;

  // One digit per cycle, most significant first: shift the digit into the
  // partial remainder and reduce it with a short restoring chain.
  always_comb begin
    logic [AccW-1:0] acc;
    logic [AccW-1:0] sub;
    acc = {rem_q, sh_q[PadW-1 -: DIGIT_W]};
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      sub = AccW'(divisor_i) << j;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    rem_next = acc[TS_W-1:0];
  end

  // Digit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(Digits);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Dividend shifter and partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= PadW'(dividend_i);
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      sh_q  <= sh_q << DIGIT_W;
      rem_q <= rem_next;
    end
  end

  assign done_o = (cnt_q == CntW'(1));
  assign rem_o  = rem_next;

endmodule

// ----- src/hmap_mem.sv -----
module hmap_mem import hmap_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  mem_ctl_t                 ctl_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [KEY_WIDTH-1:0]     wkey_i,
  input  logic [DATA_W-1:0]        wval_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [KEY_WIDTH-1:0]     rkey_o,
  output logic [DATA_W-1:0]        rval_o
);

  logic [KEY_WIDTH-1:0] key_mem [DEPTH];
  logic [DATA_W-1:0]    val_mem [DEPTH];

  // Key store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.key_we) begin
      key_mem[waddr_i] <= wkey_i;
    end
    rkey_o <= key_mem[raddr_i];
  end

  // Value store, read at the same address as the key store.
  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[waddr_i] <= wval_i;
    end
    rval_o <= val_mem[raddr_i];
  end

endmodule

// ----- src/linear_probe_hash_map_core.sv -----
// Set/get first reduce the biased key to the home slot remainder (4-bit digit
// unit), then wait on one key store read, probe the slots in turn and give the result.
// A request whose biased key is zero, or an unused code, goes straight to the result.
// Clear sweeps the key store one slot a cycle to empty, then gives the result.
// Throughput: one request at a time; busy drops in the cycle after the result strobe.
// After reset the key store is swept to empty with busy high.
module linear_probe_hash_map_core import hmap_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  req_t              req_i,
  output logic              rsp_valid_o,
  output rsp_t              rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int IdxW = $clog2(DEPTH);
  localparam logic [TS_W-1:0] DepthClip =
      TS_W'((DEPTH > (1 << TS_W) - 1) ? (1 << TS_W) - 1 : DEPTH);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(DEPTH - 1);

  cfg_t                 cfg;
  state_e               state_q, state_d;
  logic [TS_W-1:0]      idx_q;
  logic [TS_W-1:0]      cnt_q;
  logic [IdxW-1:0]      sweep_q;
  logic [KEY_WIDTH-1:0] biased_q;
  logic [KEY_WIDTH-1:0] biased_d;
  logic [DATA_W-1:0]    value_q;
  logic                 is_set_q;
  rsp_t                 rsp_q;

  logic [TS_W-1:0]      n_act;
  logic [TS_W-1:0]      idx_next;
  logic                 accept;
  logic                 is_set_d;
  logic                 is_lookup;
  logic                 mod_start;
  logic                 mod_done;
  logic [TS_W-1:0]      mod_rem;
  logic                 hit;
  logic                 empty;
  logic                 last_probe;
  logic                 sweep_end;

  mem_ctl_t             mem_ctl;
  logic [IdxW-1:0]      waddr;
  logic [KEY_WIDTH-1:0] wkey;
  logic [IdxW-1:0]      raddr;
  logic [KEY_WIDTH-1:0] rkey;
  logic [DATA_W-1:0]    rval;

  hmap_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hmap_mod #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (biased_d),
    .divisor_i  (n_act),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  hmap_mem #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wkey_i  (wkey),
    .wval_i  (value_q),
    .raddr_i (raddr),
    .rkey_o  (rkey),
    .rval_o  (rval)
  );

  // Active table size: zero counts as one slot, and it saturates at the depth (clipped to the TS_W range).
  always_comb begin
    if (cfg.table_size == '0) begin
      n_act = TS_W'(1);
    end else if (cfg.table_size > DepthClip) begin
      n_act = DepthClip;
    end else begin
      n_act = cfg.table_size;
    end
  end

  // Request decode and key bias.
  assign accept    = start && (state_q == ST_IDLE);
  assign biased_d  = KEY_WIDTH'(req_i.key) - KEY_WIDTH'(cfg.key_low) + KEY_WIDTH'(1);
  assign is_set_d  = (req_i.func == FUNC_SET);
  assign is_lookup = is_set_d || (req_i.func == FUNC_GET);
  assign mod_start = accept && is_lookup && (biased_d != '0);

  // Probe status for the slot whose key is on the read port.
  assign hit        = (rkey == biased_q);
  assign empty      = (rkey == '0);
  assign last_probe = ((cnt_q + TS_W'(1)) == n_act);
  assign idx_next   = ((idx_q + TS_W'(1)) >= n_act) ? '0 : idx_q + TS_W'(1);
  assign sweep_end  = (sweep_q == LastSlot);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.func == FUNC_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (mod_start) begin
            state_d = ST_MOD;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_MOD: begin
        if (mod_done) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: state_d = ST_PROBE;
      ST_PROBE: begin
        if (hit || empty || last_probe) state_d = ST_RESP;
      end
      ST_CLEAR: begin
        if (sweep_end) state_d = ST_RESP;
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory controls: sweeps write empty keys, probes write on a set that
  // matched or found a free slot, and reads run one slot ahead while probing.
  always_comb begin
    mem_ctl = '0;
    waddr   = IdxW'(idx_q);
    wkey    = biased_q;
    raddr   = IdxW'(idx_q);
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        mem_ctl.key_we = 1'b1;
        waddr          = sweep_q;
        wkey           = '0;
      end
      ST_PROBE: begin
        raddr = IdxW'(idx_next);
        if (is_set_q && hit) begin
          mem_ctl.val_we = 1'b1;
        end else if (is_set_q && empty) begin
          mem_ctl.key_we = 1'b1;
          mem_ctl.val_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INIT || state_q == ST_CLEAR) begin
        sweep_q <= sweep_q + IdxW'(1);
      end else begin
        sweep_q <= '0;
      end
    end
  end

  // Request context, probe position and result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      biased_q           <= biased_d;
      value_q            <= req_i.value;
      is_set_q           <= is_set_d;
      rsp_q.result_value <= (req_i.func == FUNC_GET) ? req_i.value : '0;
      rsp_q.found        <= 1'b0;
      rsp_q.full_res     <= 1'b0;
    end
    if (state_q == ST_MOD && mod_done) begin
      idx_q <= mod_rem;
      cnt_q <= '0;
    end
    if (state_q == ST_PROBE) begin
      if (hit) begin
        rsp_q.found <= 1'b1;
        if (!is_set_q) rsp_q.result_value <= rval;
      end else if (!empty) begin
        if (last_probe) begin
          rsp_q.full_res <= 1'b1;
        end else begin
          idx_q <= idx_next;
          cnt_q <= cnt_q + TS_W'(1);
        end
      end
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign rsp_valid_o = (state_q == ST_RESP);
  assign rsp_o       = rsp_q;

`ifndef ASSERT_OFF
  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o) else $error("result strobe held longer than one cycle");

  // A result never reports both a hit and a full table.
  a_found_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.found && rsp_o.full_res)) else $error("found and full both set");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("request accepted but block not busy");

  // The probe position stays inside the active table.
  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (idx_q < n_act)) else $error("probe index out of range");
`endif

endmodule
